[rtl/core/adsu_pkg.sv]
// Shared types and codes for the array deque with search unit.
`default_nettype none

package adsu_pkg;

  // Request action codes
  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_COUNT      = 3'd4;
  localparam logic [2:0] ACT_FIND       = 3'd5;
  localparam logic [2:0] ACT_READ       = 3'd6;

  // Result status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_FULL      = 2'd1;
  localparam logic [1:0] STS_EMPTY     = 2'd2;
  localparam logic [1:0] STS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [3:0]         index;
  } adsu_req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic               found;
    logic [1:0]         status;
    logic [4:0]         occupancy;
  } adsu_res_t;

  // Controls broadcast to every cell of the chain
  typedef struct packed {
    logic shift_up;    // take left neighbor's entry (insert at front)
    logic shift_down;  // take right neighbor's entry (remove front)
    logic capture;     // latch compare result against the request word
    logic scan;        // pass match bits one cell toward the head
  } adsu_ctrl_t;

endpackage : adsu_pkg

`default_nettype wire

[rtl/core/adsu_cell.sv]
// One storage cell of the deque chain: entry register, comparator, match bit.
`default_nettype none

module adsu_cell #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire adsu_pkg::adsu_ctrl_t   ctrl_i,
  input  wire logic                   load_i,
  input  wire logic                   in_range_i,
  input  wire logic [WORD_BITS-1:0]   word_i,
  input  wire logic [WORD_BITS-1:0]   prev_entry_i,
  input  wire logic [WORD_BITS-1:0]   next_entry_i,
  input  wire logic                   next_match_i,
  output logic      [WORD_BITS-1:0]   entry_o,
  output logic                        match_o
);
  import adsu_pkg::*;

  logic [WORD_BITS-1:0] entry_d, entry_q;
  logic                 match_d, match_q;

  always_comb begin
    entry_d = entry_q;
    if (load_i) begin
      entry_d = word_i;
    end else if (ctrl_i.shift_up) begin
      entry_d = prev_entry_i;
    end else if (ctrl_i.shift_down) begin
      entry_d = next_entry_i;
    end
  end

  always_comb begin
    match_d = match_q;
    if (ctrl_i.capture) begin
      match_d = in_range_i && (entry_q == word_i);
    end else if (ctrl_i.scan) begin
      match_d = next_match_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule : adsu_cell

`default_nettype wire

[rtl/core/array_deque_with_search_unit.sv]
// Top level of the array deque with search: cell chain plus request sequencer.
//
//   channel   | handshake           | payload
//   ----------+---------------------+--------------------------------------
//   request   | start / busy        | req_i : adsu_req_t (action,value,index)
//   result    | done_o (1-cycle)    | res_o : adsu_res_t (data,found,status,
//             |                     |         occupancy)
//
// A request is taken on a clock edge with start high and busy low.
// Push, pop and read requests finish in the accepting cycle; their result
// shows on the next cycle and a new request may be taken in that same cycle.
// Count and find on a non-empty deque: every cell compares in the
// accepting cycle, then the match bits march toward the head of the chain,
// one cell per cycle, and the head bit is tallied; busy is high meanwhile.
// Reset clears the occupancy and the sequencer; entries hold no reset value.
// done_o is a one-cycle strobe with no back-pressure.
`default_nettype none

module array_deque_with_search_unit #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire adsu_pkg::adsu_req_t req_i,
  output logic                     done_o,
  output adsu_pkg::adsu_res_t      res_o
);
  import adsu_pkg::*;

  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int RD_CELLS = (DEPTH < 16) ? DEPTH : 16;  // reachable by a 4-bit index

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic             state_d, state_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic [CNT_W-1:0] acc_d, acc_q;        // running match tally
  logic [IDX_W-1:0] pos_d, pos_q;        // chain position at the head
  logic             hit_d, hit_q;
  logic [IDX_W-1:0] hit_idx_d, hit_idx_q;
  logic             is_find_d, is_find_q;
  adsu_res_t        res_d, res_q;
  logic             res_valid_d, res_valid_q;

  logic                 accept;
  logic                 push_back_go;
  adsu_ctrl_t           ctrl;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] entry [DEPTH];
  logic [DEPTH-1:0]     match;
  logic [DEPTH-1:0]     load_vec;
  logic [DEPTH-1:0]     in_range;
  logic [WORD_BITS-1:0] rd_entry;
  logic                 rd_ok;
  logic                 full;
  logic                 empty;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q == ST_SCAN);
  assign full   = (count_q == CNT_W'(DEPTH));
  assign empty  = (count_q == '0);

  // Request value, sign-extended or truncated to the stored word width
  assign word = WORD_BITS'(req_i.value);

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] prev_entry;
    logic [WORD_BITS-1:0] next_entry;
    logic                 next_match;

    if (i == 0) begin : g_head
      assign prev_entry = word;            // insert at front lands here
    end else begin : g_body
      assign prev_entry = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry = entry[i];
      assign next_match = 1'b0;
    end else begin : g_mid
      assign next_entry = entry[i+1];
      assign next_match = match[i+1];
    end

    assign load_vec[i] = push_back_go && (count_q == CNT_W'(i));
    assign in_range[i] = (CNT_W'(i) < count_q);

    adsu_cell #(
      .WORD_BITS(WORD_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .load_i      (load_vec[i]),
      .in_range_i  (in_range[i]),
      .word_i      (word),
      .prev_entry_i(prev_entry),
      .next_entry_i(next_entry),
      .next_match_i(next_match),
      .entry_o     (entry[i]),
      .match_o     (match[i])
    );
  end

  // Read port: only the first sixteen cells are addressable
  always_comb begin
    rd_entry = '0;
    for (int k = 0; k < RD_CELLS; k++) begin
      if (req_i.index == 4'(k)) begin
        rd_entry = entry[k];
      end
    end
  end

  assign rd_ok = (9'(req_i.index) < 9'(count_q));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    acc_d        = acc_q;
    pos_d        = pos_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    is_find_d    = is_find_q;
    res_d        = res_q;
    res_valid_d  = 1'b0;
    ctrl         = '0;
    push_back_go = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d       = '0;
          res_valid_d = 1'b1;
          case (req_i.action)
            ACT_PUSH_FRONT: begin
              if (full) begin
                res_d.status = STS_FULL;
              end else begin
                ctrl.shift_up = 1'b1;
                count_d       = count_q + CNT_W'(1);
              end
            end
            ACT_PUSH_BACK: begin
              if (full) begin
                res_d.status = STS_FULL;
              end else begin
                push_back_go = 1'b1;
                count_d      = count_q + CNT_W'(1);
              end
            end
            ACT_POP_FRONT: begin
              if (empty) begin
                res_d.status = STS_EMPTY;
              end else begin
                ctrl.shift_down = 1'b1;
                count_d         = count_q - CNT_W'(1);
              end
            end
            ACT_POP_BACK: begin
              if (empty) begin
                res_d.status = STS_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            ACT_COUNT, ACT_FIND: begin
              if (empty) begin
                // nothing stored: count is zero, find misses
                if (req_i.action == ACT_FIND) begin
                  res_d.status = STS_NOT_FOUND;
                end
              end else begin
                ctrl.capture = 1'b1;
                res_valid_d  = 1'b0;
                state_d      = ST_SCAN;
                acc_d        = '0;
                pos_d        = '0;
                hit_d        = 1'b0;
                hit_idx_d    = '0;
                is_find_d    = (req_i.action == ACT_FIND);
              end
            end
            ACT_READ: begin
              if (rd_ok) begin
                res_d.data  = 32'(rd_entry);
                res_d.found = 1'b1;
              end else begin
                res_d.status = STS_NOT_FOUND;
              end
            end
            default: begin
              // unused code: no change, all-zero result but for the occupancy
            end
          endcase
          res_d.occupancy = 5'(count_d);
        end
      end

      ST_SCAN: begin
        // head cell shows the match bit of position pos_q
        ctrl.scan = 1'b1;
        acc_d     = acc_q + CNT_W'(match[0]);
        if (match[0] && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = pos_q;
        end
        pos_d = pos_q + IDX_W'(1);
        if (CNT_W'(pos_q) + CNT_W'(1) == count_q) begin
          state_d         = ST_IDLE;
          res_valid_d     = 1'b1;
          res_d           = '0;
          res_d.occupancy = 5'(count_q);
          if (is_find_q) begin
            if (hit_d) begin
              res_d.data  = 32'(hit_idx_d);
              res_d.found = 1'b1;
            end else begin
              res_d.status = STS_NOT_FOUND;
            end
          end else begin
            res_d.data = 32'(acc_d);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    pos_q     <= pos_d;
    hit_q     <= hit_d;
    hit_idx_q <= hit_idx_d;
    is_find_q <= is_find_d;
    res_q     <= res_d;
  end

  assign done_o = res_valid_q;
  assign res_o  = res_q;

endmodule : array_deque_with_search_unit

`default_nettype wire

[bench/tb_array_deque_with_search_unit.sv]
// Self-checking testbench for the array deque with search unit.
`timescale 1ns / 100ps

module tb_array_deque_with_search_unit;
  import adsu_pkg::*;

  localparam int DEPTH        = 16;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1370;
  // Count/find scan the whole occupancy; leave room for the longest one.
  localparam int SETTLE_CYCLES = DEPTH + 8;
  // The limit sits far above the slowest correct run; keep a wide margin.
  localparam int CYCLE_LIMIT  = 400000;

  // Action code the block leaves unused; it must be answered but change nothing.
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  adsu_req_t req_i;
  logic      done_o;
  adsu_res_t res_o;

  array_deque_with_search_unit #(
    .DEPTH    (DEPTH),
    .WORD_BITS(32)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  // ------------------------------------------------------------------
  // Shadow deque: contents and fill level as the block should hold them
  // ------------------------------------------------------------------
  logic signed [31:0] deque_words [DEPTH];
  int                 deque_fill;

  // Results owed by the block, oldest first
  adsu_res_t due_results [$];

  int mismatch_count;
  int cycle_count;

  // Sender pacing: requests go out in bursts, separated by idle gaps
  int burst_left;

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Hard stop in case the block stops answering
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Apply one request to the shadow deque and return the result it must produce.
  function automatic adsu_res_t apply_deque_op(input adsu_req_t r);
    adsu_res_t res;
    int        i;
    res = '0;
    case (r.action)
      ACT_PUSH_FRONT: begin
        if (deque_fill >= DEPTH) begin
          res.status = STS_FULL;
        end else begin
          for (i = deque_fill; i > 0; i--) deque_words[i] = deque_words[i-1];
          deque_words[0] = r.value;
          deque_fill++;
        end
      end
      ACT_PUSH_BACK: begin
        if (deque_fill >= DEPTH) begin
          res.status = STS_FULL;
        end else begin
          deque_words[deque_fill] = r.value;
          deque_fill++;
        end
      end
      ACT_POP_FRONT: begin
        if (deque_fill == 0) begin
          res.status = STS_EMPTY;
        end else begin
          for (i = 0; i + 1 < deque_fill; i++) deque_words[i] = deque_words[i+1];
          deque_fill--;
        end
      end
      ACT_POP_BACK: begin
        if (deque_fill == 0) res.status = STS_EMPTY;
        else deque_fill--;
      end
      ACT_COUNT: begin
        for (i = 0; i < deque_fill; i++)
          if (deque_words[i] == r.value) res.data = res.data + 32'sd1;
      end
      ACT_FIND: begin
        // first match wins
        res.status = STS_NOT_FOUND;
        for (i = 0; i < deque_fill; i++) begin
          if (!res.found && deque_words[i] == r.value) begin
            res.data   = i;
            res.found  = 1'b1;
            res.status = STS_OK;
          end
        end
      end
      ACT_READ: begin
        if (int'(r.index) < deque_fill) begin
          res.data  = deque_words[r.index];
          res.found = 1'b1;
        end else begin
          res.status = STS_NOT_FOUND;
        end
      end
      default: ;
    endcase
    res.occupancy = deque_fill[4:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // ------------------------------------------------------------------
  // Result checker: every strobe is matched against the oldest owed result
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    adsu_res_t want;
    if (rst_ni && done_o) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with no request outstanding", res_o.data, '0);
      end else begin
        want = due_results[0];
        due_results.delete(0);
        if (res_o.data !== want.data)
          report_mismatch("data", res_o.data, want.data);
        if (res_o.found !== want.found)
          report_mismatch("found", 32'(res_o.found), 32'(want.found));
        if (res_o.status !== want.status)
          report_mismatch("status", 32'(res_o.status), 32'(want.status));
        if (res_o.occupancy !== want.occupancy)
          report_mismatch("occupancy", 32'(res_o.occupancy), 32'(want.occupancy));
      end
    end
  end

  // After each accepted request: keep start up inside a burst, else idle a while.
  // Now and then a long burst runs with no gaps at all.
  task automatic pace_after_accept();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(30, 60);
      else burst_left = $urandom_range(0, 9);
    end
  endtask

  // Present one request and hold it until the block takes it.
  // Called right after a rising edge.
  task automatic send_request(input logic [2:0] act, input logic signed [31:0] val,
                              input logic [3:0] idx);
    adsu_req_t r;
    r.action = act;
    r.value  = val;
    r.index  = idx;
    start <= 1'b1;
    req_i <= r;
    // busy as sampled at the edge is what the block itself sees
    do @(posedge clk_i); while (busy);
    due_results.push_back(apply_deque_op(r));
    pace_after_accept();
  endtask

  // ------------------------------------------------------------------
  // Directed tests
  // ------------------------------------------------------------------

  // Everything that can go wrong on an empty deque.
  task automatic test_empty_deque();
    send_request(ACT_POP_FRONT, 32'sd0, 4'd0);
    send_request(ACT_POP_BACK, -32'sd1, 4'd0);
    send_request(ACT_COUNT, 32'sd0, 4'd0);
    send_request(ACT_FIND, 32'sd0, 4'd0);
    send_request(ACT_READ, 32'sd0, 4'd0);
  endtask

  // Alternate front/back inserts with extreme words and repeats until full,
  // then try one more insert at each end.
  task automatic test_fill_to_capacity();
    logic signed [31:0] w;
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0: w = 32'sh8000_0000;
        1: w = 32'sh7FFF_FFFF;
        2: w = 32'sd7;
        default: w = $urandom;
      endcase
      send_request(i[0] ? ACT_PUSH_BACK : ACT_PUSH_FRONT, w, 4'(i));
    end
    send_request(ACT_PUSH_FRONT, 32'sd1, 4'd0);
    send_request(ACT_PUSH_BACK, -32'sd1, 4'd15);
  endtask

  // Longest scans: count and find over a full deque, plus the top slot and an unused code.
  task automatic test_search_when_full();
    send_request(ACT_COUNT, 32'sd7, 4'd0);
    send_request(ACT_FIND, 32'sd7, 4'd0);
    send_request(ACT_FIND, 32'sh0000_1234, 4'd0);
    send_request(ACT_READ, 32'sd0, 4'd15);
    send_request(ACT_UNUSED, 32'sh7FFF_FFFF, 4'd15);
  endtask

  // Pop from both ends, then read a slot that is no longer occupied.
  task automatic test_drain_ends();
    send_request(ACT_POP_FRONT, 32'sd0, 4'd0);
    send_request(ACT_POP_BACK, 32'sd0, 4'd0);
    send_request(ACT_READ, 32'sd0, 4'd15);
  endtask

  // ------------------------------------------------------------------
  // Random traffic: the fill level drifts under fill, drain and balanced
  // regimes so that empty and full are both reached many times; search
  // words come mostly from a small pool or from stored entries so that
  // counts and finds hit.
  // ------------------------------------------------------------------
  task automatic test_random_traffic(input int n_items);
    int                 regime;
    int                 roll;
    int                 push_pct;
    int                 pop_pct;
    int                 search_pct;
    logic [2:0]         act;
    logic signed [31:0] val;
    logic [3:0]         idx;
    regime = 0;
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) regime = $urandom_range(0, 2);
      case (regime)
        0:       begin push_pct = 45; pop_pct = 55; search_pct = 95; end
        1:       begin push_pct = 15; pop_pct = 60; search_pct = 97; end
        default: begin push_pct = 35; pop_pct = 65; search_pct = 98; end
      endcase

      roll = $urandom_range(0, 99);
      if (roll < push_pct)
        act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      else if (roll < pop_pct)
        act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
      else if (roll < search_pct)
        act = ACT_COUNT + 3'($urandom_range(0, 2));
      else
        act = ACT_UNUSED;

      case ($urandom_range(0, 3))
        0: val = $signed(32'($urandom_range(0, 7))) - 32'sd3;
        1: val = (deque_fill > 0) ? deque_words[$urandom_range(0, deque_fill - 1)]
                                  : $signed($urandom);
        2: val = $signed($urandom);
        default: begin
          case ($urandom_range(0, 3))
            0: val = 32'sh8000_0000;
            1: val = 32'sh7FFF_FFFF;
            2: val = 32'sd0;
            default: val = -32'sd1;
          endcase
        end
      endcase

      // reads mostly land on occupied slots, the rest anywhere
      if (act == ACT_READ && deque_fill > 0 && $urandom_range(0, 9) < 7)
        idx = 4'($urandom_range(0, deque_fill - 1));
      else
        idx = 4'($urandom_range(0, 15));

      send_request(act, val, idx);
    end
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_i          = '0;
    deque_fill     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 4;
    for (int i = 0; i < DEPTH; i++) deque_words[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_deque();
    test_fill_to_capacity();
    test_search_when_full();
    test_drain_ends();
    test_random_traffic(RANDOM_ITEMS);

    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    // any stray strobe after the last result is caught here
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
